/* rtl/srsw_pkg.sv */
package srsw_pkg;

	localparam int WINDOW_MAX = 32;
	localparam int SLOT_W     = $clog2(WINDOW_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int PKT_W      = 16;
	localparam int WS_W       = 6;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [WS_W-1:0]  WS_RESET = WS_W'(4);
	localparam logic [PKT_W-1:0] TP_RESET = PKT_W'(20);

	typedef enum logic {
		REG_WINDOW = 1'b0,
		REG_TOTAL  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_SEND    = 2'd0,
		CMD_ACK_POS = 2'd1,
		CMD_ACK_NEG = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_EMIT  = 2'd1,
		BK_DRAIN = 2'd2
	} bk_state_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic             valid;
		logic [PKT_W-1:0] packet_number;
		logic             retransmitted;
		logic [PKT_W-1:0] frame_number;
		logic             last;
		logic             all_done;
	} result_t;

endpackage

/* rtl/selective_repeat_sender_window.sv */
// Selective-repeat ARQ sender window.
// Items enter on start/action/ack_negative and are taken when start is high
// and busy is low. A four-beat command queue sits between intake and the
// frame engine, so acks are taken one per cycle while a frame is out until
// the queue is full. Ack items give no result; the idle engine pops them.
// A send item gives one beat per packet on result_valid and the result
// ports, resends first, then fresh numbers, with last on the final beat.
// After pickup the engine issues one slot per cycle through the resend list
// read, the slot store read and the result register, so beats follow one
// per cycle; it takes no new item until the frame's last beat has passed
// the reads. Once all packets are delivered a send gives a single all_done
// beat in the cycle after pickup. Each result beat is shown for one cycle
// only; the receiver cannot stall. Reset clears counters, the queue and the
// registers (window 4, total 20); the slot stores are not cleared and are
// only read where written. Registers: window_size at 0x0, total_packets at
// 0x4, written only while idle by the user; the block does not enforce it.
module selective_repeat_sender_window import srsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              action,
	input  logic              ack_negative,
	output logic              busy,
	output logic              result_valid,
	output logic [PKT_W-1:0]  packet_number,
	output logic              retransmitted,
	output logic [PKT_W-1:0]  frame_number,
	output logic              last,
	output logic              all_done,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	logic [WS_W-1:0]  window_size_q;
	logic [PKT_W-1:0] total_packets_q;
	logic             cfg_wr;
	reg_idx_t         reg_idx;
	q_head_t          head;
	logic             pop;
	result_t          res;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);

	always_comb begin
		unique case (reg_idx)
			REG_WINDOW: prdata = DATA_W'(window_size_q);
			REG_TOTAL:  prdata = DATA_W'(total_packets_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= WS_RESET;
			total_packets_q <= TP_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WINDOW: window_size_q   <= pwdata[WS_W-1:0];
				REG_TOTAL:  total_packets_q <= pwdata[PKT_W-1:0];
				default:    ;
			endcase
		end
	end

	srsw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.ack_negative (ack_negative),
		.busy         (busy),
		.head         (head),
		.pop          (pop)
	);

	srsw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.window_size   (window_size_q),
		.total_packets (total_packets_q),
		.res           (res)
	);

	assign result_valid  = res.valid;
	assign packet_number = res.packet_number;
	assign retransmitted = res.retransmitted;
	assign frame_number  = res.frame_number;
	assign last          = res.last;
	assign all_done      = res.all_done;

endmodule

/* rtl/srsw_front.sv */
module srsw_front import srsw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    action,
	input  logic    ack_negative,
	output logic    busy,
	output q_head_t head,
	input  logic    pop
);

	cmd_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;
	cmd_t              cmd_in;

	always_comb begin
		unique case ({action, ack_negative})
			2'b10:   cmd_in = CMD_ACK_POS;
			2'b11:   cmd_in = CMD_ACK_NEG;
			default: cmd_in = CMD_SEND;
		endcase
	end

	assign busy       = (count_q == QCNT_W'(QDEPTH));
	assign push       = start && !busy;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/srsw_back.sv */
module srsw_back import srsw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  q_head_t          head,
	output logic             pop,
	input  logic [WS_W-1:0]  window_size,
	input  logic [PKT_W-1:0] total_packets,
	output result_t          res
);

	// resend list holds slot indices of the current frame, not packet numbers
	logic [SLOT_W-1:0] resend_list [WINDOW_MAX];
	logic [PKT_W-1:0]  frame_slots [WINDOW_MAX];

	bk_state_t state_q, state_d;

	logic [CNT_W-1:0] rc_q;
	logic [CNT_W-1:0] fl_q;
	logic [CNT_W-1:0] ack_slot_q;
	logic [PKT_W-1:0] next_fresh_q;
	logic [PKT_W-1:0] delivered_q;
	logic [PKT_W-1:0] frames_sent_q;

	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W-1:0] rcs_q;
	logic [CNT_W-1:0] base_q;
	logic [PKT_W-1:0] fn_q;
	logic [CNT_W-1:0] issue_q;

	logic              v_s1;
	logic [SLOT_W-1:0] s_s1;
	logic [SLOT_W-1:0] rl_rd_s1;
	logic              v_s2;
	logic [SLOT_W-1:0] s_s2;
	logic              rt_s2;
	logic [PKT_W-1:0]  fs_rd_s2;

	logic             issue;
	logic             do_send;
	logic             do_ack;
	logic             fin;
	logic [CNT_W:0]   resend_wide;
	logic [CNT_W-1:0] resend_n;
	logic [CNT_W-1:0] win;
	logic [PKT_W-1:0] rem;
	logic [CNT_W-1:0] room;
	logic [CNT_W-1:0] fresh;
	logic [CNT_W-1:0] n_calc;
	logic [CNT_W-1:0] off_s1;
	logic [CNT_W-1:0] src_wide;
	logic [SLOT_W-1:0] src_s1;
	logic             rt_s1;
	logic [PKT_W-1:0] pkt_s2;

	assign fin = (delivered_q >= total_packets);

	// frame sizing: resends = queued negatives plus unacked tail of last frame
	always_comb begin
		resend_wide = {1'b0, rc_q} + {1'b0, fl_q} - {1'b0, ack_slot_q};
		resend_n    = resend_wide[CNT_W-1:0];
		if ({1'b0, window_size} > (WS_W + 1)'(WINDOW_MAX)) begin
			win = CNT_W'(WINDOW_MAX);
		end else begin
			win = CNT_W'(window_size);
		end
		rem   = (total_packets > next_fresh_q) ? (total_packets - next_fresh_q) : '0;
		room  = (win > resend_n) ? (win - resend_n) : '0;
		fresh = (rem < PKT_W'(room)) ? rem[CNT_W-1:0] : room;
		n_calc = resend_n + fresh;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid && head.cmd == CMD_SEND && !fin && n_calc != '0) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (issue_q == n_q - 1'b1) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		issue = 1'b0;
		unique case (state_q)
			BK_IDLE:  pop   = head.valid;
			BK_EMIT:  issue = 1'b1;
			BK_DRAIN: ;
			default:  ;
		endcase
	end

	assign do_send = pop && head.cmd == CMD_SEND;
	assign do_ack  = pop && head.cmd != CMD_SEND && ack_slot_q < fl_q;

	// stage 1 source slot: from the list first, then the unacked tail
	always_comb begin
		off_s1   = {1'b0, s_s1} - rcs_q;
		src_wide = base_q + off_s1;
		src_s1   = ({1'b0, s_s1} < rcs_q) ? rl_rd_s1 : src_wide[SLOT_W-1:0];
		rt_s1    = ({1'b0, s_s1} < r_q);
	end

	assign pkt_s2 = rt_s2 ? fs_rd_s2 : next_fresh_q;

	// source reads always sit at or above the slot being written
	always_ff @(posedge clk) begin
		if (do_ack && head.cmd == CMD_ACK_NEG) begin
			resend_list[rc_q[SLOT_W-1:0]] <= ack_slot_q[SLOT_W-1:0];
		end
		if (v_s2) begin
			frame_slots[s_s2] <= pkt_s2;
		end
		rl_rd_s1 <= resend_list[issue_q[SLOT_W-1:0]];
		fs_rd_s2 <= frame_slots[src_s1];
		s_s1     <= issue_q[SLOT_W-1:0];
		s_s2     <= s_s1;
		rt_s2    <= rt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			rc_q          <= '0;
			fl_q          <= '0;
			ack_slot_q    <= '0;
			next_fresh_q  <= '0;
			delivered_q   <= '0;
			frames_sent_q <= '0;
			n_q           <= '0;
			r_q           <= '0;
			rcs_q         <= '0;
			base_q        <= '0;
			fn_q          <= '0;
			issue_q       <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			res.valid     <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;

			if (do_ack) begin
				ack_slot_q <= ack_slot_q + 1'b1;
				if (head.cmd == CMD_ACK_NEG) begin
					rc_q <= rc_q + 1'b1;
				end else if (delivered_q != '1) begin
					delivered_q <= delivered_q + 1'b1;
				end
			end

			if (do_send && !fin) begin
				rc_q       <= '0;
				fl_q       <= n_calc;
				ack_slot_q <= '0;
				n_q        <= n_calc;
				r_q        <= resend_n;
				rcs_q      <= rc_q;
				base_q     <= ack_slot_q;
				fn_q       <= frames_sent_q;
				issue_q    <= '0;
				if (n_calc != '0) begin
					frames_sent_q <= frames_sent_q + 1'b1;
				end
			end else if (issue) begin
				issue_q <= issue_q + 1'b1;
			end

			if (v_s2 && !rt_s2) begin
				next_fresh_q <= next_fresh_q + 1'b1;
			end

			if (do_send && fin) begin
				res.valid         <= 1'b1;
				res.packet_number <= '0;
				res.retransmitted <= 1'b0;
				res.frame_number  <= frames_sent_q;
				res.last          <= 1'b0;
				res.all_done      <= 1'b1;
			end else if (v_s2) begin
				res.valid         <= 1'b1;
				res.packet_number <= pkt_s2;
				res.retransmitted <= rt_s2;
				res.frame_number  <= fn_q;
				res.last          <= ({1'b0, s_s2} == n_q - 1'b1);
				res.all_done      <= 1'b0;
			end else begin
				res.valid <= 1'b0;
			end
		end
	end

endmodule

/* bench/tb_selective_repeat_sender_window.sv */
module tb_selective_repeat_sender_window;
	import srsw_pkg::*;

	localparam int DRAIN_CYCLES = 4 * (WINDOW_MAX + 3) + 8;
	localparam int SESSIONS     = 12;
	localparam int SESSION_ITEMS = 32;

	typedef struct {
		logic [PKT_W-1:0] pkt;
		logic             resent;
		logic [PKT_W-1:0] frame;
		logic             last;
		logic             done;
	} beat_t;

	class arq_scoreboard;
		logic [PKT_W-1:0] slot_pkt [WINDOW_MAX];
		logic [PKT_W-1:0] resend_q [WINDOW_MAX];
		int unsigned      resend_cnt;
		int unsigned      fresh_next;
		int unsigned      acked;
		int unsigned      frame_len;
		int unsigned      ack_idx;
		logic [PKT_W-1:0] frames_out;
		logic [WS_W-1:0]  win_cfg;
		logic [PKT_W-1:0] total_cfg;
		beat_t            due_beats[$];
		int               errors;

		function new();
			win_cfg = WS_RESET;
			total_cfg = TP_RESET;
			resend_cnt = 0;
			fresh_next = 0;
			acked = 0;
			frame_len = 0;
			ack_idx = 0;
			frames_out = '0;
			errors = 0;
		endfunction

		function void report_mismatch(string msg);
			$display("mismatch @%0t: %s", $time, msg);
			errors++;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
			if (idx == REG_WINDOW)
				win_cfg = val[WS_W-1:0];
			else
				total_cfg = val[PKT_W-1:0];
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		function void queue_resend(logic [PKT_W-1:0] pkt);
			if (resend_cnt < WINDOW_MAX) begin
				resend_q[resend_cnt] = pkt;
				resend_cnt++;
			end
		endfunction

		// Returns 1 unless the beat is an ack beyond the current frame.
		function bit advance_window(bit act, bit neg);
			int unsigned win;
			int unsigned n;
			int unsigned n_re;
			beat_t b;
			if (act) begin
				if (ack_idx >= frame_len)
					return 1'b0;
				if (neg)
					queue_resend(slot_pkt[ack_idx]);
				else if (acked < 16'hFFFF)
					acked++;
				ack_idx++;
				return 1'b1;
			end
			if (acked >= total_cfg) begin
				b = '{pkt: '0, resent: 1'b0, frame: frames_out, last: 1'b0, done: 1'b1};
				due_beats.push_back(b);
				return 1'b1;
			end
			// unacked slots of the previous frame go back as negatives
			while (ack_idx < frame_len) begin
				queue_resend(slot_pkt[ack_idx]);
				ack_idx++;
			end
			win = (win_cfg > WINDOW_MAX) ? WINDOW_MAX : win_cfg;
			n = 0;
			for (int unsigned r = 0; r < resend_cnt && n < WINDOW_MAX; r++) begin
				slot_pkt[n] = resend_q[r];
				n++;
			end
			n_re = n;
			while (n < win && fresh_next < total_cfg) begin
				slot_pkt[n] = PKT_W'(fresh_next);
				fresh_next++;
				n++;
			end
			resend_cnt = 0;
			frame_len = n;
			ack_idx = 0;
			if (n == 0)
				return 1'b1;
			for (int unsigned s = 0; s < n; s++) begin
				b = '{pkt: slot_pkt[s], resent: (s < n_re), frame: frames_out,
					last: (s + 1 == n), done: 1'b0};
				due_beats.push_back(b);
			end
			frames_out++;
			return 1'b1;
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			if (due_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat pkt=%0d frame=%0d done=%0b",
					got.pkt, got.frame, got.done));
				return;
			end
			want = due_beats.pop_front();
			if (got.pkt !== want.pkt)
				report_mismatch($sformatf("packet_number %0d, want %0d", got.pkt, want.pkt));
			if (got.resent !== want.resent)
				report_mismatch($sformatf("retransmitted %0b, want %0b (pkt %0d)",
					got.resent, want.resent, want.pkt));
			if (got.frame !== want.frame)
				report_mismatch($sformatf("frame_number %0d, want %0d",
					got.frame, want.frame));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %0b, want %0b (pkt %0d)",
					got.last, want.last, want.pkt));
			if (got.done !== want.done)
				report_mismatch($sformatf("all_done %0b, want %0b", got.done, want.done));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              action = 1'b0;
	logic              ack_negative = 1'b0;
	logic              busy;
	logic              result_valid;
	logic [PKT_W-1:0]  packet_number;
	logic              retransmitted;
	logic [PKT_W-1:0]  frame_number;
	logic              last;
	logic              all_done;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	arq_scoreboard sb = new();
	int idle_pct = 0;
	int fed = 0;

	selective_repeat_sender_window uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(action),
		.ack_negative(ack_negative),
		.busy(busy),
		.result_valid(result_valid),
		.packet_number(packet_number),
		.retransmitted(retransmitted),
		.frame_number(frame_number),
		.last(last),
		.all_done(all_done),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		beat_t got;
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			got = '{pkt: packet_number, resent: retransmitted, frame: frame_number,
				last: last, done: all_done};
			sb.check_beat(got);
		end
	end

	// Leaves start high after the beat unless a gap is drawn.
	task automatic push_item(bit act, bit neg);
		start <= 1'b1;
		action <= act;
		ack_negative <= neg;
		do @(posedge clk); while (busy !== 1'b0);
		if (sb.advance_window(act, neg))
			fed++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// acks and empty frames may still sit in the engine
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(idx) * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_reg(idx, val);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rd = prdata;
			@(posedge clk);
		end while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		want = (idx == REG_WINDOW) ? DATA_W'(val[WS_W-1:0]) : DATA_W'(val[PKT_W-1:0]);
		if (rd !== want)
			sb.report_mismatch($sformatf("readback of %s gave %0h, want %0h",
				idx.name(), rd, want));
	endtask

	task automatic run_session(int target);
		int unsigned n;
		int mode;
		int n_acks;
		fed = 0;
		while (fed < target) begin
			if ($urandom_range(0, 99) < 8) begin
				push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				push_item(1'b0, 1'($urandom_range(0, 1)));
				n = sb.frame_len - sb.ack_idx;
				mode = $urandom_range(0, 99);
				if (mode < 70)
					n_acks = n;
				else if (mode < 85)
					n_acks = $urandom_range(0, n);
				else
					n_acks = n + $urandom_range(1, 3);
				for (int k = 0; k < n_acks; k++)
					push_item(1'b1, $urandom_range(0, 99) < 20);
			end
		end
	endtask

	initial begin
		logic [DATA_W-1:0] win_val;
		logic [DATA_W-1:0] total_val;
		int pick;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: window 4, total 20 from reset
		idle_pct = 29;
		push_item(1'b0, 1'b0);
		push_item(1'b1, 1'b0);
		push_item(1'b1, 1'b1);
		push_item(1'b1, 1'b0);
		// fourth slot left unacked, resent with the nack'd one
		push_item(1'b0, 1'b1);
		push_item(1'b1, 1'b1);
		push_item(1'b1, 1'b0);
		push_item(1'b1, 1'b0);
		push_item(1'b1, 1'b0);
		push_item(1'b1, 1'b1);
		settle();

		// zero window: resends only, then an empty frame
		cfg_write(REG_WINDOW, 32'd0);
		push_item(1'b0, 1'b0);
		push_item(1'b1, 1'b1);
		push_item(1'b0, 1'b0);
		push_item(1'b1, 1'b0);
		push_item(1'b0, 1'b1);
		settle();

		// oversized window saturates at the store depth
		cfg_write(REG_WINDOW, 32'd63);
		cfg_write(REG_TOTAL, 32'd65535);
		push_item(1'b0, 1'b0);
		push_item(1'b1, 1'b0);
		push_item(1'b1, 1'b1);
		push_item(1'b0, 1'b0);
		settle();

		cfg_write(REG_TOTAL, 32'd0);
		push_item(1'b0, 1'b1);
		push_item(1'b1, 1'b1);
		settle();

		cfg_write(REG_WINDOW, 32'd1);
		cfg_write(REG_TOTAL, 32'd65535);
		push_item(1'b0, 1'b0);
		push_item(1'b1, 1'b0);
		settle();

		for (int s = 0; s < SESSIONS; s++) begin
			idle_pct = (s < 4) ? 29 : (s < 8) ? 74 : 0;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				win_val = 0;
			else if (pick < 15)
				win_val = 32;
			else if (pick < 22)
				win_val = $urandom_range(33, 63);
			else
				win_val = $urandom_range(1, 8);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				total_val = 65535;
			else if (pick < 20)
				total_val = sb.acked >> 1;
			else if (pick < 25)
				total_val = 0;
			else if (sb.fresh_next + 40 > 65535)
				total_val = 65535;
			else
				total_val = sb.fresh_next + $urandom_range(4, 40);
			cfg_write(REG_WINDOW, win_val);
			cfg_write(REG_TOTAL, total_val);
			run_session(SESSION_ITEMS);
			settle();
		end

		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
